### rtl/brus_pkg.sv
// ---------------------------------------------------------------------------
// brus_pkg: shared types and constants for the 2x glyph row upscaler
// Job record passed from the row front end to the output sequencer, plus
// queue sizing and glyph geometry constants.
// ---------------------------------------------------------------------------
package brus_pkg;

  // Widest glyph supported, in source columns
  localparam int MAX_GLYPH_WIDTH = 8;
  localparam int SRC_W           = 8;
  localparam int OUT_W           = 16;
  localparam int GW_W            = 4;
  localparam logic [GW_W-1:0] GLYPH_WIDTH_RESET = GW_W'(5);

  // Rows per job and index/count width
  localparam int MAX_ROWS = 3;
  localparam int ROW_CNT_W = 2;

  // Job queue geometry
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QFILL_W = 2;

  // One source row's worth of output rows, in emission order
  typedef struct packed {
    logic [MAX_ROWS-1:0][OUT_W-1:0] rows;
    logic [ROW_CNT_W-1:0]           count;
    logic                           last;
  } job_t;

endpackage

### rtl/brus_if.sv
// ---------------------------------------------------------------------------
// brus_if: valid/ready channels of the upscaler
// Source row channel and scaled row channel, each with source/sink views.
// ---------------------------------------------------------------------------
interface brus_row_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_bits;
  logic       last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface brus_row_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_row_bits;
  logic        last_of_item;
  logic        last_of_glyph;

  modport source (output valid, output out_row_bits, output last_of_item,
                  output last_of_glyph, input ready);
  modport sink   (input valid, input out_row_bits, input last_of_item,
                  input last_of_glyph, output ready);
endinterface

### rtl/brus_front.sv
// ---------------------------------------------------------------------------
// brus_front: source row front end
// Holds the width register and the previous row, doubles and smooths each
// accepted source row into a job of one to three output rows.
// ---------------------------------------------------------------------------
module brus_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_wdata,
  brus_row_in_if.sink           glyph,
  output logic                  push,
  output brus_pkg::job_t        push_job,
  input  logic                  full
);

  // Cell patterns {top-left, top-right, bottom-left, bottom-right}
  localparam logic [3:0] ANTI_DIAG = 4'b0110;
  localparam logic [3:0] MAIN_DIAG = 4'b1001;

  logic [brus_pkg::GW_W-1:0]  glyph_width;
  logic [brus_pkg::SRC_W-1:0] previous_row;
  logic                       have_previous;

  logic [brus_pkg::GW_W-1:0]  eff_w;
  logic [brus_pkg::SRC_W-1:0] mask;
  logic [brus_pkg::SRC_W-1:0] cur;
  logic [brus_pkg::SRC_W-1:0] prev;
  logic [brus_pkg::OUT_W-1:0] cur_sp;
  logic [brus_pkg::OUT_W-1:0] prev_sp;
  logic [brus_pkg::OUT_W-1:0] up_px;
  logic [brus_pkg::OUT_W-1:0] lo_px;
  logic                       accept;

  // each source bit k becomes output bits 2k+1 and 2k
  function automatic logic [brus_pkg::OUT_W-1:0] spread(
      input logic [brus_pkg::SRC_W-1:0] row);
    logic [brus_pkg::OUT_W-1:0] o;
    o = '0;
    for (int k = 0; k < brus_pkg::SRC_W; k++) begin
      o[2*k]   = row[k];
      o[2*k+1] = row[k];
    end
    return o;
  endfunction

  // clamp width to the supported maximum
  always_comb begin
    if (glyph_width > brus_pkg::GW_W'(brus_pkg::MAX_GLYPH_WIDTH)) begin
      eff_w = brus_pkg::GW_W'(brus_pkg::MAX_GLYPH_WIDTH);
    end else begin
      eff_w = glyph_width;
    end
    for (int k = 0; k < brus_pkg::SRC_W; k++) begin
      mask[k] = (brus_pkg::GW_W'(k) < eff_w);
    end
  end

  assign cur     = glyph.row_bits & mask;
  assign prev    = previous_row & mask;
  assign cur_sp  = spread(cur);
  assign prev_sp = spread(prev);

  // diagonal smoothing over adjacent column pairs, each cell independent
  always_comb begin
    logic [3:0] cellv;
    up_px = '0;
    lo_px = '0;
    for (int k = 1; k < brus_pkg::SRC_W; k++) begin
      cellv = {prev[k], prev[k-1], cur[k], cur[k-1]};
      if (brus_pkg::GW_W'(k) < eff_w) begin
        if (cellv == ANTI_DIAG) begin
          up_px[2*k]   = 1'b1;
          lo_px[2*k-1] = 1'b1;
        end
        if (cellv == MAIN_DIAG) begin
          up_px[2*k-1] = 1'b1;
          lo_px[2*k]   = 1'b1;
        end
      end
    end
  end

  // job assembly
  always_comb begin
    push_job.last = glyph.last_row;
    if (have_previous) begin
      push_job.rows[0] = prev_sp | up_px;
      push_job.rows[1] = cur_sp | lo_px;
      push_job.rows[2] = cur_sp;
      push_job.count   = glyph.last_row ? brus_pkg::ROW_CNT_W'(3) : brus_pkg::ROW_CNT_W'(2);
    end else begin
      push_job.rows[0] = cur_sp;
      push_job.rows[1] = cur_sp;
      push_job.rows[2] = cur_sp;
      push_job.count   = glyph.last_row ? brus_pkg::ROW_CNT_W'(2) : brus_pkg::ROW_CNT_W'(1);
    end
  end

  assign glyph.ready = !full;
  assign accept      = glyph.valid && !full;
  assign push        = accept;

  // width register and row history
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width   <= brus_pkg::GLYPH_WIDTH_RESET;
      previous_row  <= '0;
      have_previous <= 1'b0;
    end else begin
      if (cfg_we) begin
        glyph_width <= cfg_wdata;
      end
      if (accept) begin
        if (glyph.last_row) begin
          previous_row  <= '0;
          have_previous <= 1'b0;
        end else begin
          previous_row  <= glyph.row_bits;
          have_previous <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/brus_queue.sv
// ---------------------------------------------------------------------------
// brus_queue: job queue
// Short FIFO of jobs between the front end and the output sequencer.
// ---------------------------------------------------------------------------
module brus_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brus_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output brus_pkg::job_t head,
  output logic           empty
);

  brus_pkg::job_t                 mem [brus_pkg::QDEPTH];
  logic [brus_pkg::QPTR_W-1:0]    wr_ptr;
  logic [brus_pkg::QPTR_W-1:0]    rd_ptr;
  logic [brus_pkg::QFILL_W-1:0]   fill;

  assign full  = (fill == brus_pkg::QFILL_W'(brus_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == brus_pkg::QPTR_W'(brus_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == brus_pkg::QPTR_W'(brus_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/brus_back.sv
// ---------------------------------------------------------------------------
// brus_back: output row sequencer
// Walks the rows of the head job into the output register, one per beat.
// ---------------------------------------------------------------------------
module brus_back (
  input  logic            clk,
  input  logic            rst,
  input  brus_pkg::job_t  head,
  input  logic            empty,
  output logic            pop,
  brus_row_out_if.source  scaled
);

  logic                            out_valid;
  logic [brus_pkg::OUT_W-1:0]      out_bits;
  logic                            out_loi;
  logic                            out_log;
  logic [brus_pkg::ROW_CNT_W-1:0]  idx;

  logic load;
  logic take;
  logic last_beat;

  // output register may refill when empty or being drained
  assign load      = !out_valid || scaled.ready;
  assign take      = load && !empty;
  assign last_beat = (idx == head.count - 1'b1);
  assign pop       = take && last_beat;

  assign scaled.valid         = out_valid;
  assign scaled.out_row_bits  = out_bits;
  assign scaled.last_of_item  = out_loi;
  assign scaled.last_of_glyph = out_log;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        idx <= last_beat ? '0 : idx + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_bits <= head.rows[idx];
      out_loi  <= last_beat;
      out_log  <= last_beat && head.last;
    end
  end

endmodule

### rtl/bitmap_row_upscale_2x_smooth.sv
// ---------------------------------------------------------------------------
// bitmap_row_upscale_2x_smooth: 2x glyph upscaler with diagonal smoothing
// Source rows in, doubled and smoothed output rows out.
// ---------------------------------------------------------------------------
// Usage:
//   glyph  : source rows (row_bits, last_row), valid/ready. A beat is taken
//            whenever the two-entry job queue has room.
//   scaled : output rows (out_row_bits, last_of_item, last_of_glyph). Each
//            source row yields one to three output beats.
//   cfg_we/cfg_wdata : glyph_width, write only while the block is idle.
// Order: an accepted source beat's job is written into the queue, and its
//   rows then pass one at a time through the output register.
// Throughput: the output register delivers one row per cycle while the
//   receiver is ready; a source row produces 1 to 3 rows (2 for a steady
//   stream of inner rows); input beats are taken back to back while the
//   queue has space.
// Reset: glyph_width returns to 5, the row history and queue empty out.
// Receiver stall: the output row holds; the queue fills and then the
//   source channel drops ready until rows drain.
// ---------------------------------------------------------------------------
module bitmap_row_upscale_2x_smooth (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_wdata,
  brus_row_in_if.sink    glyph,
  brus_row_out_if.source scaled
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  brus_pkg::job_t push_job;
  brus_pkg::job_t head;

  brus_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .glyph     (glyph),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  brus_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  brus_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .scaled (scaled)
  );

endmodule
